>>> rtl/core/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, token kind codes and byte classes for the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  // Default widths of the running offset and the line/column counters
  localparam int unsigned OFFSET_WIDTH_DEF   = 32;
  localparam int unsigned POSITION_WIDTH_DEF = 16;

  // Result queue depth (power of two, at least 4)
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

  // Token kind codes
  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_PLUS   = 5'd1;
  localparam logic [4:0] KIND_MINUS  = 5'd2;
  localparam logic [4:0] KIND_SLASH  = 5'd3;
  localparam logic [4:0] KIND_STAR   = 5'd4;
  localparam logic [4:0] KIND_COMMA  = 5'd5;
  localparam logic [4:0] KIND_COLON  = 5'd6;
  localparam logic [4:0] KIND_SEMI   = 5'd7;
  localparam logic [4:0] KIND_LBRACE = 5'd8;
  localparam logic [4:0] KIND_RBRACE = 5'd9;
  localparam logic [4:0] KIND_LBRACK = 5'd10;
  localparam logic [4:0] KIND_RBRACK = 5'd11;
  localparam logic [4:0] KIND_LPAREN = 5'd12;
  localparam logic [4:0] KIND_RPAREN = 5'd13;
  localparam logic [4:0] KIND_PIPE   = 5'd14;
  localparam logic [4:0] KIND_DOT    = 5'd15;
  localparam logic [4:0] KIND_ARROW  = 5'd16;
  localparam logic [4:0] KIND_ISEQ   = 5'd17;
  localparam logic [4:0] KIND_EQUAL  = 5'd18;
  localparam logic [4:0] KIND_IDENT  = 5'd19;
  localparam logic [4:0] KIND_NUMBER = 5'd20;
  localparam logic [4:0] KIND_ERROR  = 5'd21;

  // Characters with special meaning
  localparam logic [7:0] CH_GT      = 8'h3E;  // '>'
  localparam logic [7:0] CH_EQ      = 8'h3D;  // '='
  localparam logic [7:0] CH_UNDER   = 8'h5F;  // '_'
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PIPE    = 8'h7C;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  tok_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_text;
  } out_item_t;

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_TAB) || (b == CH_VTAB) || (b == CH_CR) ||
           (b == CH_NEWLINE) || (b == CH_SPACE);
  endfunction

  function automatic logic is_single(logic [7:0] b);
    logic hit;
    case (b)
      CH_NUL, CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_COMMA, CH_COLON,
      CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_LPAREN,
      CH_RPAREN, CH_PIPE, CH_DOT: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] b);
    logic [4:0] k;
    case (b)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_SLASH:  k = KIND_SLASH;
      CH_STAR:   k = KIND_STAR;
      CH_COMMA:  k = KIND_COMMA;
      CH_COLON:  k = KIND_COLON;
      CH_SEMI:   k = KIND_SEMI;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_PIPE:   k = KIND_PIPE;
      CH_DOT:    k = KIND_DOT;
      default:   k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/stok_fifo.sv
// ----------------------------------------------------------------------------
// stok_fifo
// Small token queue: takes zero, one or two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
module stok_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_cnt_i,
  input  stok_pkg::out_item_t  push0_i,
  input  stok_pkg::out_item_t  push1_i,
  input  logic                 pop_i,
  output logic                 room2_o,
  output logic                 valid_o,
  output stok_pkg::out_item_t  data_o
);

  localparam int unsigned Depth  = stok_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);

  stok_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                pop;

  assign pop      = pop_i && (count_q != '0);
  assign valid_o  = (count_q != '0);
  assign data_o   = mem_q[rd_ptr_q];
  assign room2_o  = (count_q <= CountW'(Depth - 2));
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CountW'(push_cnt_i) - CountW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

endmodule

>>> rtl/core/stok_lexer.sv
// ----------------------------------------------------------------------------
// stok_lexer
// Per-byte classify and update of the running token state; yields up to two
// tokens per byte.
// ----------------------------------------------------------------------------
module stok_lexer #(
  parameter int unsigned OFFSET_WIDTH   = stok_pkg::OFFSET_WIDTH_DEF,
  parameter int unsigned POSITION_WIDTH = stok_pkg::POSITION_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  stok_pkg::in_item_t   item_i,
  output stok_pkg::out_item_t  res0_o,
  output stok_pkg::out_item_t  res1_o,
  output logic [1:0]           res_cnt_o
);

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_EQUAL,
    PEND_IDENT,
    PEND_NUMBER
  } pend_e;

  localparam logic [POSITION_WIDTH-1:0] PosMax = {POSITION_WIDTH{1'b1}};

  pend_e                     pend_q, pend_d;
  logic [OFFSET_WIDTH-1:0]   tok_start_q, tok_start_d;
  logic [15:0]               tok_len_q, tok_len_d, tok_len_inc;
  logic [POSITION_WIDTH-1:0] tok_line_q, tok_line_d;
  logic [POSITION_WIDTH-1:0] tok_col_q, tok_col_d;
  logic [OFFSET_WIDTH-1:0]   offset_q, offset_d;
  logic [POSITION_WIDTH-1:0] line_q, line_d;
  logic [POSITION_WIDTH-1:0] col_q, col_d;
  logic                      err_q, err_d;

  logic [7:0]  b;
  logic        eot;
  logic        fresh;
  logic        a_v, f_v, e_v, c_v;
  logic [4:0]  a_kind, f_kind, e_kind;
  logic [15:0] a_len;
  stok_pkg::out_item_t tok_a, tok_f, tok_e, tok_c;

  function automatic stok_pkg::out_item_t make_tok(
    logic [4:0] kind, logic [OFFSET_WIDTH-1:0] start, logic [15:0] len,
    logic [POSITION_WIDTH-1:0] line, logic [POSITION_WIDTH-1:0] col);
    stok_pkg::out_item_t t;
    t.tok_kind      = kind;
    t.start_offset  = 32'(start);
    t.token_length  = len;
    t.line_number   = 16'(line);
    t.column_number = 16'(col);
    t.last_of_text  = 1'b0;
    return t;
  endfunction

  assign b   = item_i.text_byte;
  assign eot = item_i.end_of_text;
  assign tok_len_inc = (tok_len_q == stok_pkg::LENGTH_MAX) ? tok_len_q
                                                           : tok_len_q + 16'd1;

  // Token decisions: pending close (a), fresh byte (f), end-of-text flush (e)
  always_comb begin
    pend_d      = pend_q;
    tok_start_d = tok_start_q;
    tok_len_d   = tok_len_q;
    tok_line_d  = tok_line_q;
    tok_col_d   = tok_col_q;
    err_d       = err_q;
    fresh       = 1'b1;
    a_v         = 1'b0;
    a_kind      = stok_pkg::KIND_EQUAL;
    a_len       = 16'd1;
    f_v         = 1'b0;
    f_kind      = stok_pkg::KIND_ERROR;
    e_v         = 1'b0;
    e_kind      = stok_pkg::KIND_EQUAL;

    if (!err_q) begin
      case (pend_q)
        PEND_EQUAL: begin
          a_v    = 1'b1;
          pend_d = PEND_NONE;
          if (b == stok_pkg::CH_GT) begin
            a_kind = stok_pkg::KIND_ARROW;
            a_len  = 16'd2;
            fresh  = 1'b0;
          end else if (b == stok_pkg::CH_EQ) begin
            a_kind = stok_pkg::KIND_ISEQ;
            a_len  = 16'd2;
            fresh  = 1'b0;
          end
        end
        PEND_IDENT: begin
          if (stok_pkg::is_letter(b) || stok_pkg::is_digit(b) ||
              (b == stok_pkg::CH_UNDER)) begin
            tok_len_d = tok_len_inc;
            fresh     = 1'b0;
          end else begin
            a_v    = 1'b1;
            a_kind = stok_pkg::KIND_IDENT;
            a_len  = tok_len_q;
            pend_d = PEND_NONE;
          end
        end
        PEND_NUMBER: begin
          if (stok_pkg::is_letter(b) || stok_pkg::is_digit(b)) begin
            tok_len_d = tok_len_inc;
            fresh     = 1'b0;
          end else begin
            a_v    = 1'b1;
            a_kind = stok_pkg::KIND_NUMBER;
            a_len  = tok_len_q;
            pend_d = PEND_NONE;
          end
        end
        default: ;
      endcase

      // Fresh byte: skip, single token, start a pending token, or error
      if (fresh && !stok_pkg::is_space(b)) begin
        if (stok_pkg::is_single(b)) begin
          f_v    = 1'b1;
          f_kind = stok_pkg::single_kind(b);
        end else if ((b == stok_pkg::CH_EQ) || stok_pkg::is_letter(b) ||
                     (b == stok_pkg::CH_UNDER) || stok_pkg::is_digit(b)) begin
          if (b == stok_pkg::CH_EQ) begin
            pend_d = PEND_EQUAL;
          end else if (stok_pkg::is_digit(b)) begin
            pend_d = PEND_NUMBER;
          end else begin
            pend_d = PEND_IDENT;
          end
          tok_start_d = offset_q;
          tok_len_d   = 16'd1;
          tok_line_d  = line_q;
          tok_col_d   = col_q;
        end else begin
          f_v    = 1'b1;
          f_kind = stok_pkg::KIND_ERROR;
          err_d  = 1'b1;
        end
      end

      // Flush whatever is still pending at end of text
      if (eot && !err_d && (pend_d != PEND_NONE)) begin
        e_v = 1'b1;
        case (pend_d)
          PEND_IDENT:  e_kind = stok_pkg::KIND_IDENT;
          PEND_NUMBER: e_kind = stok_pkg::KIND_NUMBER;
          default:     e_kind = stok_pkg::KIND_EQUAL;
        endcase
      end
    end
  end

  // Position counters
  always_comb begin
    if (b == stok_pkg::CH_NEWLINE) begin
      col_d  = '0;
      line_d = (line_q == PosMax) ? line_q : line_q + POSITION_WIDTH'(1);
    end else begin
      col_d  = (col_q == PosMax) ? col_q : col_q + POSITION_WIDTH'(1);
      line_d = line_q;
    end
    offset_d = offset_q + OFFSET_WIDTH'(1);
  end

  // Result assembly
  always_comb begin
    tok_a = make_tok(a_kind, tok_start_q, a_len, tok_line_q, tok_col_q);
    tok_f = make_tok(f_kind, offset_q, 16'd1, line_q, col_q);
    tok_e = make_tok(e_kind, tok_start_d,
                     (pend_d == PEND_EQUAL) ? 16'd1 : tok_len_d,
                     tok_line_d, tok_col_d);
    c_v   = f_v || e_v;
    tok_c = f_v ? tok_f : tok_e;

    res0_o = a_v ? tok_a : tok_c;
    res1_o = tok_c;
    res0_o.last_of_text = eot && !(a_v && c_v);
    res1_o.last_of_text = eot;
    res_cnt_o = {a_v && c_v, a_v ^ c_v};
  end

  // Running state; end of text returns everything to the start condition
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= PEND_NONE;
      tok_start_q <= '0;
      tok_len_q   <= '0;
      tok_line_q  <= '0;
      tok_col_q   <= '0;
      offset_q    <= '0;
      line_q      <= '0;
      col_q       <= '0;
      err_q       <= 1'b0;
    end else if (step_i) begin
      if (eot) begin
        pend_q      <= PEND_NONE;
        tok_start_q <= '0;
        tok_len_q   <= '0;
        tok_line_q  <= '0;
        tok_col_q   <= '0;
        offset_q    <= '0;
        line_q      <= '0;
        col_q       <= '0;
        err_q       <= 1'b0;
      end else begin
        pend_q      <= pend_d;
        tok_start_q <= tok_start_d;
        tok_len_q   <= tok_len_d;
        tok_line_q  <= tok_line_d;
        tok_col_q   <= tok_col_d;
        offset_q    <= offset_d;
        line_q      <= line_d;
        col_q       <= col_d;
        err_q       <= err_d;
      end
    end
  end

endmodule

>>> rtl/core/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming maximal-munch tokenizer: one text byte in, tokens out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue has room and emits one token per
// cycle while out_ready_i is high. A byte is held in an input register,
// classified combinationally against the running token state, and its
// tokens (zero, one or two) go into a four-entry output queue; a token passes
// the input register and then the queue before it is presented at the output.
// Input is accepted every cycle while the queue has room for two tokens, so
// the sustained rate is one byte per cycle as long as the tokens are drained
// at one per cycle; a byte that closes one token and makes another (e.g. "a+")
// yields two tokens, which leave one after another through the single-token
// output port. A byte marked end_of_text flushes any open token, tags the
// final token with last_of_text and restarts offset, line and column at 0.
module source_tokenizer #(
  parameter int unsigned OFFSET_WIDTH   = stok_pkg::OFFSET_WIDTH_DEF,
  parameter int unsigned POSITION_WIDTH = stok_pkg::POSITION_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stok_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stok_pkg::out_item_t  out_item_o
);

  logic                in_valid_q;
  stok_pkg::in_item_t  in_item_q;
  logic                step;
  logic                room2;
  logic [1:0]          res_cnt;
  stok_pkg::out_item_t res0, res1;

  // Input register advances when the queue can absorb a worst-case byte
  assign step       = in_valid_q && room2;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  stok_lexer #(
    .OFFSET_WIDTH   (OFFSET_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  stok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (step ? res_cnt : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (out_ready_i),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .data_o     (out_item_o)
  );

endmodule
